>>> rtl/core/spq_pkg.sv
// Scale pitch quantiser package: configuration struct, scale interval masks
// and small arithmetic helpers shared by the quantiser modules.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int unsigned PITCH_W   = 7;
    localparam int unsigned CODE_W    = 4;
    localparam int unsigned ROOT_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 4;
    localparam int unsigned NUM_PC    = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_NOTE    = 2'd1;

    // scale codes
    localparam logic [CODE_W-1:0] SCALE_MAJOR      = 4'd0;
    localparam logic [CODE_W-1:0] SCALE_NAT_MINOR  = 4'd1;
    localparam logic [CODE_W-1:0] SCALE_HARM_MINOR = 4'd2;
    localparam logic [CODE_W-1:0] SCALE_DORIAN     = 4'd3;
    localparam logic [CODE_W-1:0] SCALE_PHRYGIAN   = 4'd4;
    localparam logic [CODE_W-1:0] SCALE_LYDIAN     = 4'd5;
    localparam logic [CODE_W-1:0] SCALE_MIXOLYDIAN = 4'd6;
    localparam logic [CODE_W-1:0] SCALE_LOCRIAN    = 4'd7;
    localparam logic [CODE_W-1:0] SCALE_MAJ_PENTA  = 4'd8;
    localparam logic [CODE_W-1:0] SCALE_MIN_PENTA  = 4'd9;
    localparam logic [CODE_W-1:0] SCALE_CHROMATIC  = 4'd10;
    localparam logic [CODE_W-1:0] SCALE_WHOLE_TONE = 4'd11;

    // interval masks: bit t set when the tone t semitones above the root is in the scale
    localparam logic [NUM_PC-1:0] MASK_MAJOR      = 12'hAB5;
    localparam logic [NUM_PC-1:0] MASK_NAT_MINOR  = 12'h5AD;
    localparam logic [NUM_PC-1:0] MASK_HARM_MINOR = 12'h9AD;
    localparam logic [NUM_PC-1:0] MASK_DORIAN     = 12'h6AD;
    localparam logic [NUM_PC-1:0] MASK_PHRYGIAN   = 12'h5AB;
    localparam logic [NUM_PC-1:0] MASK_LYDIAN     = 12'hAD5;
    localparam logic [NUM_PC-1:0] MASK_MIXOLYDIAN = 12'h6B5;
    localparam logic [NUM_PC-1:0] MASK_LOCRIAN    = 12'h56B;
    localparam logic [NUM_PC-1:0] MASK_MAJ_PENTA  = 12'h295;
    localparam logic [NUM_PC-1:0] MASK_MIN_PENTA  = 12'h4A9;
    localparam logic [NUM_PC-1:0] MASK_CHROMATIC  = 12'hFFF;
    localparam logic [NUM_PC-1:0] MASK_WHOLE_TONE = 12'h555;

    typedef struct packed {
        logic [CODE_W-1:0] scale_select;
        logic [ROOT_W-1:0] root_note;
    } spq_cfg_t;

    function automatic logic [NUM_PC-1:0] scale_mask(input logic [CODE_W-1:0] code);
        logic [NUM_PC-1:0] m;
        case (code)
            SCALE_MAJOR:      m = MASK_MAJOR;
            SCALE_NAT_MINOR:  m = MASK_NAT_MINOR;
            SCALE_HARM_MINOR: m = MASK_HARM_MINOR;
            SCALE_DORIAN:     m = MASK_DORIAN;
            SCALE_PHRYGIAN:   m = MASK_PHRYGIAN;
            SCALE_LYDIAN:     m = MASK_LYDIAN;
            SCALE_MIXOLYDIAN: m = MASK_MIXOLYDIAN;
            SCALE_LOCRIAN:    m = MASK_LOCRIAN;
            SCALE_MAJ_PENTA:  m = MASK_MAJ_PENTA;
            SCALE_MIN_PENTA:  m = MASK_MIN_PENTA;
            SCALE_CHROMATIC:  m = MASK_CHROMATIC;
            SCALE_WHOLE_TONE: m = MASK_WHOLE_TONE;
            default:          m = MASK_CHROMATIC;
        endcase
        return m;
    endfunction

    // reduce a value below 48 modulo twelve by compare and subtract
    function automatic logic [3:0] mod12(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        if (r >= 6'd24) begin
            r = r - 6'd24;
        end
        if (r >= 6'd12) begin
            r = r - 6'd12;
        end
        return r[3:0];
    endfunction

    // octave of a 0..127 pitch: multiply by 43/512, exact over that range
    function automatic logic [3:0] octave_of(input logic [PITCH_W-1:0] p);
        logic [13:0] prod;
        prod = 14'(p) * 14'd43;
        return prod[12:9];
    endfunction

endpackage

>>> rtl/core/spq_cfg.sv
// Scale pitch quantiser configuration registers (scale code and root).
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spq_pkg::CFG_DAT_W-1:0] cfg_data,
    output spq_pkg::spq_cfg_t             cfg
);

    logic [spq_pkg::CODE_W-1:0] scale_select_reg, scale_select_next;
    logic [spq_pkg::ROOT_W-1:0] root_note_reg, root_note_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        scale_select_next = scale_select_reg;
        root_note_next    = root_note_reg;
        if (cfg_valid) begin
            case (cfg_index)
                spq_pkg::REG_SCALE_SELECT: scale_select_next = cfg_data;
                spq_pkg::REG_ROOT_NOTE:    root_note_next    = cfg_data;
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_select_reg <= '0;
            root_note_reg    <= '0;
        end else begin
            scale_select_reg <= scale_select_next;
            root_note_reg    <= root_note_next;
        end
    end

    assign cfg.scale_select = scale_select_reg;
    assign cfg.root_note    = root_note_reg;

endmodule

>>> rtl/core/spq_snap.sv
// Scale pitch quantiser snapping logic: nearest in-scale pitch to a clamped
// pitch, ties to the lower one. Combinational. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_snap (
    input  logic [spq_pkg::PITCH_W-1:0] pitch,
    input  spq_pkg::spq_cfg_t           cfg,
    output logic [spq_pkg::PITCH_W-1:0] note
);

    // offsets stored as distance + 2, in order of preference: 0, -1, +1, -2, +2.
    // No scale has a gap wider than three semitones, so the winner is always
    // within two of the pitch.
    localparam int unsigned NUM_TRY = 5;
    localparam logic [2:0] TRY_OFF [NUM_TRY] = '{3'd2, 3'd1, 3'd3, 3'd0, 3'd4};

    logic [spq_pkg::NUM_PC-1:0] smask;
    logic [spq_pkg::ROOT_W-1:0] root;
    logic [3:0]                 oct;
    logic [spq_pkg::PITCH_W-1:0] oct_base;
    logic [3:0]                 pc;
    logic [NUM_TRY-1:0]         hit;
    logic [7:0]                 cand2 [NUM_TRY];

    assign smask    = spq_pkg::scale_mask(cfg.scale_select);
    assign root     = (cfg.root_note >= 4'd12) ? cfg.root_note - 4'd12 : cfg.root_note;
    assign oct      = spq_pkg::octave_of(pitch);
    assign oct_base = 7'(oct * 7'd12);
    assign pc       = 4'(pitch - oct_base);

    always_comb begin
        for (int i = 0; i < NUM_TRY; i++) begin
            logic [5:0] rel;
            logic [4:0] lo_chk;
            cand2[i] = 8'(pitch) + 8'(TRY_OFF[i]);
            rel      = 6'(pc) + 6'(TRY_OFF[i]) + 6'd22 - 6'(root);
            lo_chk   = 5'(pc) + 5'(TRY_OFF[i]) + 5'd10;
            // in range, not below the lowest octave searched, and in the scale
            hit[i] = (cand2[i] >= 8'd2) && (cand2[i] <= 8'd129)
                  && (lo_chk >= 5'(root))
                  && smask[spq_pkg::mod12(rel)];
        end
    end

    always_comb begin
        note = pitch;
        for (int i = NUM_TRY - 1; i >= 0; i--) begin
            if (hit[i]) begin
                note = 7'(cand2[i] - 8'd2);
            end
        end
    end

endmodule

>>> rtl/core/scale_pitch_quantizer.sv
// Scale pitch quantiser top level: input register, snapping logic, result register.
// Depends on spq_pkg, spq_cfg and spq_snap.
`timescale 1ns / 1ps

// Snaps each incoming note to the nearest pitch of the configured scale,
// transposed by the root; ties go to the lower pitch and the input is clamped
// to 0..127 first. One note is accepted every clock cycle unless both the
// input register and the result register hold a note and m_ready is low.
// Each note passes through the input register and then the result register,
// which presents it on m_valid. A held result does not stop the input register
// from taking a request while it is empty. Configuration writes complete in
// the cycle they are presented (cfg_ready is always high); write them only
// while no note is in flight. Scale codes 12 to 15 act as chromatic and root
// values 12 to 15 wrap modulo twelve.

module scale_pitch_quantizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [8:0]             s_note_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [6:0]                    m_note_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spq_pkg::CFG_DAT_W-1:0] cfg_data
);

    spq_pkg::spq_cfg_t cfg;

    logic                         in_valid_reg, in_valid_next;
    logic [spq_pkg::PITCH_W-1:0]  pitch_reg, pitch_next;
    logic                         m_valid_reg, m_valid_next;
    logic [spq_pkg::PITCH_W-1:0]  note_reg, note_next;
    logic [spq_pkg::PITCH_W-1:0]  snapped;
    logic                         out_adv;
    logic [spq_pkg::PITCH_W-1:0]  clamped;

    spq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spq_snap u_snap (
        .pitch (pitch_reg),
        .cfg   (cfg),
        .note  (snapped)
    );

    // clamp to 0..127: negative gives 0, bit 7 set gives 127
    assign clamped = s_note_in[8] ? 7'd0 : (s_note_in[7] ? 7'd127 : s_note_in[6:0]);

    assign out_adv = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || out_adv;

    always_comb begin
        in_valid_next = in_valid_reg;
        pitch_next    = pitch_reg;
        m_valid_next  = m_valid_reg;
        note_next     = note_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            pitch_next    = clamped;
        end
        if (out_adv) begin
            m_valid_next = in_valid_reg;
            note_next    = snapped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        pitch_reg <= pitch_next;
        note_reg  <= note_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_note_out = note_reg;

    // input side only stalls when both stages hold a request
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg))
        else $error("input stalled with a free stage");

    // result never lies more than two semitones from the clamped pitch
    a_near: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_adv && in_valid_reg) |=>
            ((8'(note_reg) + 8'd2 >= 8'($past(pitch_reg)))
             && (8'(note_reg) <= 8'($past(pitch_reg)) + 8'd2)))
        else $error("snapped note too far from input");

    // chromatic scale, and scale codes 12 to 15, pass the clamped pitch through
    a_chromatic: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_adv && in_valid_reg
         && (cfg.scale_select == spq_pkg::SCALE_CHROMATIC
             || cfg.scale_select >= 4'd12)) |=>
            (note_reg == $past(pitch_reg)))
        else $error("chromatic scale altered the pitch");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for scale_pitch_quantizer: random and directed notes under
// every scale code and root offset, checked against a scoreboard-side snapping model.
// Depends on spq_pkg and the scale_pitch_quantizer RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int NOTES_PER_SETTING = 40;
    localparam int RANDOM_SETTINGS   = 20;
    // register indexes with nothing behind them
    localparam logic [spq_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [spq_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    class pitch_scoreboard;
        localparam int PITCH_TOP = 127;

        typedef struct {
            logic signed [8:0] pitch_in;
            logic [6:0]        snapped;
        } snap_t;

        logic [spq_pkg::CODE_W-1:0] scale_code;
        logic [spq_pkg::ROOT_W-1:0] root_off;
        snap_t             awaiting[$];
        int                notes_in;
        int                notes_checked;
        int                errors;

        function new();
            scale_code    = spq_pkg::SCALE_MAJOR;
            root_off      = 4'd0;
            notes_in      = 0;
            notes_checked = 0;
            errors        = 0;
        endfunction

        function void set_reg(logic [spq_pkg::CFG_IDX_W-1:0] idx,
                              logic [spq_pkg::CFG_DAT_W-1:0] val);
            if (idx == spq_pkg::REG_SCALE_SELECT) begin
                scale_code = val;
            end else if (idx == spq_pkg::REG_ROOT_NOTE) begin
                root_off = val;
            end
        endfunction

        // bit t set when the tone t semitones above the root belongs to the scale
        function logic [11:0] tone_set(logic [spq_pkg::CODE_W-1:0] code);
            logic [11:0] tones;
            case (code)
                spq_pkg::SCALE_MAJOR:      tones = 12'b1010_1011_0101;
                spq_pkg::SCALE_NAT_MINOR:  tones = 12'b0101_1010_1101;
                spq_pkg::SCALE_HARM_MINOR: tones = 12'b1001_1010_1101;
                spq_pkg::SCALE_DORIAN:     tones = 12'b0110_1010_1101;
                spq_pkg::SCALE_PHRYGIAN:   tones = 12'b0101_1010_1011;
                spq_pkg::SCALE_LYDIAN:     tones = 12'b1010_1101_0101;
                spq_pkg::SCALE_MIXOLYDIAN: tones = 12'b0110_1011_0101;
                spq_pkg::SCALE_LOCRIAN:    tones = 12'b0101_0110_1011;
                spq_pkg::SCALE_MAJ_PENTA:  tones = 12'b0010_1001_0101;
                spq_pkg::SCALE_MIN_PENTA:  tones = 12'b0100_1010_1001;
                spq_pkg::SCALE_WHOLE_TONE: tones = 12'b0101_0101_0101;
                default:                   tones = 12'b1111_1111_1111;
            endcase
            return tones;
        endfunction

        function logic [6:0] snap(logic signed [8:0] pitch_in);
            logic [11:0] tones;
            int          pitch;
            int          root;
            int          octv;
            int          cand;
            int          delta;
            int          best;
            int          best_dist;
            tones = tone_set(scale_code);
            root  = root_off % 12;
            pitch = pitch_in;
            if (pitch < 0) begin
                pitch = 0;
            end
            if (pitch > PITCH_TOP) begin
                pitch = PITCH_TOP;
            end
            octv      = pitch / 12;
            best      = pitch;
            best_dist = 1000;
            for (int o = octv - 1; o <= octv + 1; o++) begin
                for (int t = 0; t < 12; t++) begin
                    cand = o * 12 + root + t;
                    if (tones[t] && cand >= 0 && cand <= PITCH_TOP) begin
                        delta = (cand > pitch) ? cand - pitch : pitch - cand;
                        // equal distance: keep the lower pitch
                        if (delta < best_dist || (delta == best_dist && cand < best)) begin
                            best_dist = delta;
                            best      = cand;
                        end
                    end
                end
            end
            return 7'(best);
        endfunction

        function void note_input(logic signed [8:0] pitch_in);
            snap_t item;
            item.pitch_in = pitch_in;
            item.snapped  = snap(pitch_in);
            awaiting = {awaiting, item};
            notes_in++;
        endfunction

        function void check_result(logic [6:0] got);
            snap_t item;
            if (awaiting.size() == 0) begin
                errors++;
                $display("%0t: unexpected note_out: expected none, actual %0d", $time, got);
            end else begin
                item = awaiting.pop_front();
                notes_checked++;
                if (got !== item.snapped) begin
                    errors++;
                    $display("%0t: note_out for note_in %0d (scale %0d root %0d): expected %0d, actual %0d",
                             $time, item.pitch_in, scale_code, root_off, item.snapped, got);
                end
            end
        endfunction

        function int pending();
            return awaiting.size();
        endfunction
    endclass

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic signed [8:0]             s_note_in = 9'h000;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic [6:0]                    m_note_out;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [spq_pkg::CFG_IDX_W-1:0] cfg_index = spq_pkg::REG_SCALE_SELECT;
    logic [spq_pkg::CFG_DAT_W-1:0] cfg_data  = 4'd0;

    pitch_scoreboard sb = new();
    int cycle_count   = 0;
    int burst_left    = 0;
    int settings_used = 1;

    // reset values, edge pitches and ties between neighbouring scale tones
    logic signed [8:0] reset_probe [12] = '{9'h100, 9'h1FF, 9'h000, 9'h001, 9'h006, 9'h03D,
                                            9'h042, 9'h064, 9'h07E, 9'h07F, 9'h080, 9'h0FF};
    // whole tone on root 11: a nearest tone of pitch 0 falls below 0; top-end and clamped pitches too
    logic signed [8:0] octave_probe [8] = '{9'h000, 9'h001, 9'h002, 9'h07D,
                                            9'h07E, 9'h07F, 9'h1FB, 9'h0C8};
    // unknown scale code with a root above eleven
    logic signed [8:0] wrap_probe [3] = '{9'h1FD, 9'h032, 9'h07F};

    scale_pitch_quantizer dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_note_in  (s_note_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_note_out (m_note_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run stopped at cycle %0d with %0d notes outstanding",
                     cycle_count, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver back-pressure: free-flowing, light, heavy and periodic stalls in turn
    always @(posedge aclk) begin
        case ((cycle_count / 173) % 4)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 9) < 7);
            2:       m_ready <= ($urandom_range(0, 9) < 3);
            default: m_ready <= (cycle_count % 11) < 7;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_note_out);
            end
            if (s_valid && s_ready) begin
                sb.note_input(s_note_in);
            end
            if (cfg_valid && cfg_ready) begin
                sb.set_reg(cfg_index, cfg_data);
            end
        end
    end

    function automatic logic signed [8:0] pick_note();
        case ($urandom_range(0, 9))
            0:       return 9'($urandom);
            1:       return 9'(512 - $urandom_range(1, 256));
            2:       return 9'($urandom_range(128, 255));
            3:       return 9'($urandom_range(0, 5));
            4:       return 9'($urandom_range(121, 127));
            default: return 9'($urandom_range(0, 127));
        endcase
    endfunction

    // present one request; drop valid afterwards on a gap or when told to
    task automatic send_note(input logic signed [8:0] pitch, input bit last);
        int gap;
        s_valid   <= 1'b1;
        s_note_in <= pitch;
        do @(posedge aclk); while (!s_ready);
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            case ($urandom_range(0, 7))
                0, 1, 2: gap = 0;
                3, 4, 5: gap = $urandom_range(1, 3);
                6:       gap = $urandom_range(4, 12);
                default: gap = $urandom_range(20, 40);
            endcase
        end
        if (last || gap > 0) begin
            s_valid   <= 1'b0;
            s_note_in <= 9'($urandom);
            repeat (gap) @(posedge aclk);
        end
    endtask

    // let the monitor log the last accepted request before looking at the queue
    task automatic drain();
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_reg(input logic [spq_pkg::CFG_IDX_W-1:0] idx,
                               input logic [spq_pkg::CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [spq_pkg::CODE_W-1:0] code,
                                 input logic [spq_pkg::ROOT_W-1:0] root);
        drain();
        program_reg(spq_pkg::REG_SCALE_SELECT, code);
        program_reg(spq_pkg::REG_ROOT_NOTE, root);
        settings_used++;
    endtask

    initial begin
        logic [spq_pkg::CODE_W-1:0] code;
        logic [spq_pkg::ROOT_W-1:0] root;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (reset_probe[i]) begin
            send_note(reset_probe[i], i == 11);
        end
        apply_setting(spq_pkg::SCALE_WHOLE_TONE, 4'd11);
        foreach (octave_probe[i]) begin
            send_note(octave_probe[i], i == 7);
        end
        apply_setting(4'd13, 4'd14);
        foreach (wrap_probe[i]) begin
            send_note(wrap_probe[i], i == 2);
        end

        for (int p = 0; p < RANDOM_SETTINGS; p++) begin
            if (p < 16) begin
                // walk every scale code and, through the stride, every root value
                code = 4'(p);
                root = 4'((p * 7) % 16);
            end else if (p == 16) begin
                code = spq_pkg::SCALE_MAJOR;
                root = 4'd0;
            end else if (p == 17) begin
                code = 4'd15;
                root = 4'd15;
            end else begin
                code = 4'($urandom_range(0, 15));
                root = 4'($urandom_range(0, 15));
            end
            if (p == 5) begin
                drain();
                program_reg(REG_SPARE_2, 4'($urandom));
                program_reg(REG_SPARE_3, 4'd15);
            end
            apply_setting(code, root);
            for (int n = 0; n < NOTES_PER_SETTING; n++) begin
                send_note(pick_note(), n == NOTES_PER_SETTING - 1);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Snapped %0d notes (%0d checked) under %0d register settings,",
                 sb.notes_in, sb.notes_checked, settings_used);
        $display("covering every scale code, every root value and clamped pitches.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> scale_pitch_quantizer.f
rtl/core/spq_pkg.sv
rtl/core/spq_cfg.sv
rtl/core/spq_snap.sv
rtl/core/scale_pitch_quantizer.sv
tb/testbench.sv
